[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

[rtl/dll_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dll_pkg;
  localparam int unsigned CapacityDefault = 64;

  localparam logic [2:0] OpSearch  = 3'd0;
  localparam logic [2:0] OpInsHead = 3'd1;
  localparam logic [2:0] OpInsTail = 3'd2;
  localparam logic [2:0] OpInsAft  = 3'd3;
  localparam logic [2:0] OpDelete  = 3'd4;
  localparam logic [2:0] OpClear   = 3'd5;
  localparam logic [2:0] OpSum     = 3'd6;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StMiss    = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] key;
    logic signed [31:0] anchor_key;
  } dll_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         found_slot;
    logic [6:0]         element_count;
    logic signed [63:0] key_sum;
  } dll_rsp_t;
endpackage
`default_nettype wire

[rtl/dll_free_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// Finds the lowest free slot by scanning the used bits one per cycle.
module dll_free_scan #(
  parameter int unsigned Capacity = 64,
  localparam int unsigned IdxW = $clog2(Capacity + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [Capacity-1:0] used_i,
  output logic                     done_o,
  output logic [IdxW-1:0]          slot_o
);
  logic [IdxW-1:0] idx_q, idx_d;
  logic            busy_q, busy_d;
  logic            hit;

  assign hit = (idx_q < IdxW'(Capacity)) && !used_i[idx_q[$clog2(Capacity)-1:0]];
  assign done_o = busy_q && (hit || idx_q == IdxW'(Capacity));
  assign slot_o = idx_q;

  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    if (start_i) begin
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end
endmodule
`default_nettype wire

[rtl/doubly_linked_list_engine_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Doubly linked list of signed 32-bit keys in a pool of Capacity slots. One
// request is taken at a time and answered with one result beat. Search,
// insert-after, delete and sum walk the list from the head through a single
// key/link memory port, addressing each node visited and then comparing it;
// inserts also scan the used bits for the lowest free slot at one slot per
// cycle. Clear empties the list without a walk or a scan.
module doubly_linked_list_engine_core
  import dll_pkg::*;
#(
  parameter int unsigned Capacity = dll_pkg::CapacityDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dll_pkg::dll_req_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dll_pkg::dll_rsp_t      out_data_o
);
  `include "assert_macros.svh"

  localparam int unsigned IdxW = $clog2(Capacity + 1);
  localparam int unsigned AdrW = $clog2(Capacity);
  localparam logic [IdxW-1:0] Nil = IdxW'(Capacity);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SRead  = 4'd1;
  localparam logic [3:0] SCheck = 4'd2;
  localparam logic [3:0] SFree  = 4'd3;
  localparam logic [3:0] SLink1 = 4'd4;
  localparam logic [3:0] SLink2 = 4'd5;
  localparam logic [3:0] SLink3 = 4'd6;
  localparam logic [3:0] SOut   = 4'd7;
  localparam logic [3:0] SRdNx  = 4'd8;

  logic [31:0]     mem_key  [Capacity];
  logic [IdxW-1:0] mem_next [Capacity];
  logic [IdxW-1:0] mem_prev [Capacity];

  logic [3:0]          state_q, state_d;
  dll_req_t            req_q, req_d;
  logic [Capacity-1:0] used_q, used_d;
  logic [IdxW-1:0]     head_q, head_d, tail_q, tail_d, cnt_q, cnt_d;
  logic [IdxW-1:0]     cur_q, cur_d, steps_q, steps_d, loc_q, loc_d, new_q, new_d;
  logic [63:0]         sum_q, sum_d;
  logic [1:0]          status_q, status_d;
  logic [IdxW-1:0]     slot_q, slot_d;
  logic [31:0]         rd_key_q;
  logic [IdxW-1:0]     rd_next_q, rd_prev_q;
  logic [IdxW-1:0]     rd_adr;
  logic                wr_en;
  logic [IdxW-1:0]     wr_adr, wr_next, wr_prev;
  logic [31:0]         wr_key;
  logic [2:0]          wr_sel;
  logic                scan_start, scan_done;
  logic [IdxW-1:0]     scan_slot;
  logic [31:0]         target;

  dll_free_scan #(.Capacity(Capacity)) u_scan (
    .clk_i, .rst_ni, .start_i(scan_start), .used_i(used_q),
    .done_o(scan_done), .slot_o(scan_slot)
  );

  // Bit 0 writes the key, bit 1 the next link, bit 2 the previous link.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (wr_sel[0]) mem_key[wr_adr[AdrW-1:0]]  <= wr_key;
      if (wr_sel[1]) mem_next[wr_adr[AdrW-1:0]] <= wr_next;
      if (wr_sel[2]) mem_prev[wr_adr[AdrW-1:0]] <= wr_prev;
    end
    rd_key_q  <= mem_key[rd_adr[AdrW-1:0]];
    rd_next_q <= mem_next[rd_adr[AdrW-1:0]];
    rd_prev_q <= mem_prev[rd_adr[AdrW-1:0]];
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign target = (req_q.operation == OpInsAft) ? req_q.anchor_key : req_q.key;

  always_comb begin
    out_data_o.status        = status_q;
    out_data_o.found_slot    = 6'(slot_q);
    out_data_o.element_count = 7'(cnt_q);
    out_data_o.key_sum       = sum_q;
  end

  always_comb begin
    state_d = state_q;  req_d = req_q;   used_d = used_q;
    head_d = head_q;    tail_d = tail_q; cnt_d = cnt_q;
    cur_d = cur_q;      steps_d = steps_q; loc_d = loc_q; new_d = new_q;
    sum_d = sum_q;      status_d = status_q; slot_d = slot_q;
    rd_adr = cur_q;     wr_en = 1'b0; wr_adr = '0; wr_sel = '0;
    wr_key = req_q.key; wr_next = Nil; wr_prev = Nil;
    scan_start = 1'b0;
    unique case (state_q)
      SIdle: if (in_valid_i) begin
        req_d = in_data_i; cur_d = head_q; steps_d = '0; sum_d = '0;
        status_d = StOk; slot_d = '0; loc_d = Nil;
        unique case (in_data_i.operation)
          OpSearch, OpInsAft, OpDelete, OpSum: state_d = SRead;
          OpInsHead, OpInsTail: begin scan_start = 1'b1; state_d = SFree; end
          OpClear: begin
            used_d = '0; head_d = Nil; tail_d = Nil; cnt_d = '0; state_d = SOut;
          end
          default: state_d = SOut;
        endcase
      end
      SRead: begin
        if (cur_q == Nil || steps_q == Nil) begin
          if (req_q.operation == OpSum) state_d = SOut;
          else begin status_d = StMiss; state_d = SOut; end
        end else state_d = SCheck;
      end
      SCheck: begin
        steps_d = steps_q + 1'b1;
        if (req_q.operation == OpSum) begin
          sum_d = sum_q + {{32{rd_key_q[31]}}, rd_key_q};
          cur_d = rd_next_q; state_d = SRead;
        end else if (rd_key_q == target) begin
          loc_d = cur_q;
          if (req_q.operation == OpSearch) begin
            slot_d = cur_q; state_d = SOut;
          end else if (req_q.operation == OpInsAft) begin
            scan_start = 1'b1; state_d = SFree;
          end else state_d = SLink1;
        end else begin
          cur_d = rd_next_q; state_d = SRead;
        end
      end
      SFree: if (scan_done) begin
        if (scan_slot == Nil) begin status_d = StFull; state_d = SOut; end
        else begin
          new_d = scan_slot; slot_d = scan_slot;
          used_d[scan_slot[AdrW-1:0]] = 1'b1; cnt_d = cnt_q + 1'b1;
          state_d = SLink1;
        end
      end
      SLink1: begin
        // rd_*_q still holds the node at cur_q (anchor or deleted node).
        wr_en = 1'b1;
        unique case (req_q.operation)
          OpInsHead: begin
            wr_adr = new_q; wr_sel = 3'b111; wr_prev = Nil; wr_next = head_q;
            head_d = new_q;
            if (head_q == Nil) begin tail_d = new_q; state_d = SOut; end
            else begin cur_d = head_q; state_d = SLink2; end
          end
          OpInsTail: begin
            wr_adr = new_q; wr_sel = 3'b111; wr_prev = tail_q; wr_next = Nil;
            tail_d = new_q;
            if (tail_q == Nil) begin head_d = new_q; state_d = SOut; end
            else begin cur_d = tail_q; state_d = SLink2; end
          end
          OpInsAft: begin
            wr_adr = new_q; wr_sel = 3'b111; wr_prev = loc_q; wr_next = rd_next_q;
            if (rd_next_q == Nil) tail_d = new_q;
            state_d = SLink2;
          end
          default: begin
            // Delete: unlink the node at loc_q.
            wr_en = 1'b0;
            used_d[loc_q[AdrW-1:0]] = 1'b0; slot_d = loc_q;
            if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
            if (rd_prev_q == Nil) head_d = rd_next_q;
            else begin
              wr_en = 1'b1; wr_adr = rd_prev_q; wr_sel = 3'b010; wr_next = rd_next_q;
            end
            if (rd_next_q == Nil) tail_d = rd_prev_q;
            state_d = SLink2;
          end
        endcase
      end
      SLink2: begin
        unique case (req_q.operation)
          OpInsHead: begin
            wr_en = 1'b1; wr_adr = cur_q; wr_sel = 3'b100; wr_prev = new_q;
            state_d = SOut;
          end
          OpInsTail: begin
            wr_en = 1'b1; wr_adr = cur_q; wr_sel = 3'b010; wr_next = new_q;
            state_d = SOut;
          end
          OpInsAft: begin
            wr_en = 1'b1; wr_adr = loc_q; wr_sel = 3'b010; wr_next = new_q;
            state_d = SRdNx;
          end
          default: begin
            if (rd_next_q != Nil) begin
              wr_en = 1'b1; wr_adr = rd_next_q; wr_sel = 3'b100; wr_prev = rd_prev_q;
            end
            state_d = SOut;
          end
        endcase
      end
      SRdNx: begin
        // Read back the new node to learn its successor.
        rd_adr = new_q; state_d = SLink3;
      end
      SLink3: begin
        if (rd_next_q != Nil) begin
          wr_en = 1'b1; wr_adr = rd_next_q; wr_sel = 3'b100; wr_prev = new_q;
        end
        state_d = SOut;
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; used_q <= '0; head_q <= Nil; tail_q <= Nil; cnt_q <= '0;
    end else begin
      state_q <= state_d; used_q <= used_d;
      head_q <= head_d; tail_q <= tail_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; cur_q <= cur_d; steps_q <= steps_d; loc_q <= loc_d;
    new_q <= new_d; sum_q <= sum_d; status_q <= status_d; slot_q <= slot_d;
  end

  `ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, cnt_q <= Nil, "count above capacity")
  `ASSERT_IMPL(a_empty_ends, clk_i, rst_ni, state_q == SIdle && cnt_q == '0,
               head_q == Nil && tail_q == Nil, "empty list with live ends")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
               out_valid_o, "result dropped before taken")
endmodule
`default_nettype wire
